FILE: sv/sdcd_pkg.sv
// sdcd_pkg: shared constants and types of the signed distance cost unit
// no dependencies; imported by the top level
package sdcd_pkg;

    // default geometry of the coordinate format
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration register index, taken from the word-address bit
    typedef enum logic [0:0] {
        REG_NOMINAL = 1'b0,
        REG_CLOSER  = 1'b1
    } t_reg_idx;

    localparam logic CLOSER_RESET = 1'b1;

endpackage

FILE: sv/signed_distance_cost_derivatives_unit.sv
// Signed distance cost with gradient and Hessian terms between two 2-D points. One request
// enters per cycle unless the output queue is full and stalls the pipeline; results appear in
// order after passing the bit-per-stage square root and the two bit-per-stage divider
// pipelines. A two-entry output queue keeps the pipeline moving while a result waits.
// Coincident points set zero_distance and zero the five derivative terms.
// depends on sdcd_pkg, sdcd_sqrt, sdcd_div
module signed_distance_cost_derivatives_unit
    import sdcd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PAW = (COORD_WIDTH > 32) ? 4 : 3,
    localparam int IDW = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [PAW-1:0]   paddr,
    input  logic [PDW-1:0]   pwdata,
    output logic [PDW-1:0]   prdata,
    output logic             pready,
    // request stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // first_x, first_y, second_x, second_y
    input  logic [IDW-1:0]   s_axis_tdata,
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // cost, grad_x, grad_y, hess_xx, hess_yy, hess_xy
    output logic [ODW-1:0]   m_axis_tdata,
    // zero_distance
    output logic [0:0]       m_axis_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int RB    = W + 1;
    localparam int SW    = 2 * RB;
    localparam int H     = W / 2;
    localparam int L     = W - H;
    localparam int GB    = F + 2;
    localparam int QH    = 2 * GB + 1;
    localparam int DFW   = W + 2;
    localparam int MB    = (QH > DFW) ? QH : DFW;
    localparam int SQS   = 2 * W + 2;
    localparam int SGW   = DFW + 3;
    localparam int SHW   = SGW + 2 * GB;
    localparam int GAW   = RB + GB;
    localparam int HAW   = RB + QH;
    localparam int OW    = 6 * W + 1;

    // saturate sign and magnitude to the signed output range
    function automatic logic [W-1:0] f_sat(input logic neg, input logic [MB-1:0] mag);
        logic big;
        logic [W-1:0] lo;
        logic [W-1:0] res;
        big = |mag[MB-1:W-1];
        lo  = mag[W-1:0];
        if (neg) begin
            res = big ? {1'b1, {(W-1){1'b0}}} : W'(~lo + 1'b1);
        end else begin
            res = big ? {1'b0, {(W-1){1'b1}}} : lo;
        end
        return res;
    endfunction

    // configuration registers
    logic [W-1:0] r_nominal;
    logic         r_closer;
    t_reg_idx     w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PAW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= '0;
            r_closer  <= CLOSER_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_NOMINAL: r_nominal <= pwdata[W-1:0];
                REG_CLOSER:  r_closer  <= pwdata[0];
                default:     r_closer  <= r_closer;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NOMINAL: prdata = PDW'(r_nominal);
            REG_CLOSER:  prdata = PDW'(r_closer);
            default:     prdata = '0;
        endcase
    end

    // pipeline advance and output queue control
    logic          w_en;
    logic          r_v9;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          w_push;
    logic          w_pop;

    assign w_en          = !r_v9 || (r_cnt != 2'd2) || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: coordinate differences
    logic                r_v1;
    logic signed [W:0]   r_dx;
    logic signed [W:0]   r_dy;
    logic signed [W-1:0] w_fx, w_fy, w_sx, w_sy;

    assign w_fx = s_axis_tdata[W-1:0];
    assign w_fy = s_axis_tdata[2*W-1:W];
    assign w_sx = s_axis_tdata[3*W-1:2*W];
    assign w_sy = s_axis_tdata[4*W-1:3*W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= (W+1)'(w_fx) - (W+1)'(w_sx);
            r_dy <= (W+1)'(w_fy) - (W+1)'(w_sy);
        end
    end

    // stage 2: magnitudes and signs
    logic          r_v2;
    logic [W-1:0]  r_mx2, r_my2;
    logic          r_nx2, r_ny2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx2 <= r_dx[W];
            r_ny2 <= r_dy[W];
            r_mx2 <= r_dx[W] ? W'(-r_dx) : r_dx[W-1:0];
            r_my2 <= r_dy[W] ? W'(-r_dy) : r_dy[W-1:0];
        end
    end

    // stage 3: partial products of the squares
    logic            r_v3;
    logic [W-1:0]    r_mx3, r_my3;
    logic            r_nx3, r_ny3;
    logic [2*L-1:0]  r_xhh, r_yhh;
    logic [W-1:0]    r_xhl, r_yhl;
    logic [2*H-1:0]  r_xll, r_yll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx3 <= r_mx2;
            r_my3 <= r_my2;
            r_nx3 <= r_nx2;
            r_ny3 <= r_ny2;
            r_xhh <= r_mx2[W-1:H] * r_mx2[W-1:H];
            r_xhl <= r_mx2[W-1:H] * r_mx2[H-1:0];
            r_xll <= r_mx2[H-1:0] * r_mx2[H-1:0];
            r_yhh <= r_my2[W-1:H] * r_my2[W-1:H];
            r_yhl <= r_my2[W-1:H] * r_my2[H-1:0];
            r_yll <= r_my2[H-1:0] * r_my2[H-1:0];
        end
    end

    // stage 4: sum of squares
    logic            r_v4;
    logic [SW-1:0]   r_sum;
    logic [SQS-1:0]  r_side4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= (SW'(r_xhh) << (2*H)) + (SW'(r_xhl) << (H+1)) + SW'(r_xll)
                   + (SW'(r_yhh) << (2*H)) + (SW'(r_yhl) << (H+1)) + SW'(r_yll);
            r_side4 <= {r_mx3, r_my3, r_nx3, r_ny3};
        end
    end

    // floor square root
    logic            w_sq_v;
    logic [RB-1:0]   w_sq_root;
    logic [RB+1:0]   w_sq_rem;
    logic [SQS-1:0]  w_sq_side;

    sdcd_sqrt #(
        .RB  (RB),
        .SDW (SQS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_rad   (r_sum),
        .i_side  (r_side4),
        .o_valid (w_sq_v),
        .o_root  (w_sq_root),
        .o_rem   (w_sq_rem),
        .o_side  (w_sq_side)
    );

    // stage 5: round the distance, up when the remainder exceeds the root
    logic            r_v5;
    logic [RB-1:0]   r_n5;
    logic [SQS-1:0]  r_side5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n5    <= w_sq_root + RB'(w_sq_rem > (RB+2)'(w_sq_root));
            r_side5 <= w_sq_side;
        end
    end

    // stage 6: cost difference, coincidence flag
    logic                r_v6;
    logic [RB-1:0]       r_n6;
    logic [W-1:0]        r_mx6, r_my6;
    logic                r_nx6, r_ny6, r_zero6;
    logic signed [DFW-1:0] r_diff6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n6    <= r_n5;
            r_mx6   <= r_side5[SQS-1:W+2];
            r_my6   <= r_side5[W+1:2];
            r_nx6   <= r_side5[1];
            r_ny6   <= r_side5[0];
            r_zero6 <= (r_n5 == '0);
            r_diff6 <= {{2{r_nominal[W-1]}}, r_nominal} - {1'b0, r_n5};
        end
    end

    // gradient divisions: |d| * 2^(F+1) / n
    logic [1:0][GAW-1:0]  w_gnum;
    logic                 w_gd_v;
    logic [1:0][GB-1:0]   w_gd_q;
    logic [RB-1:0]        w_gd_n;
    logic [SGW-1:0]       w_gd_side;

    assign w_gnum[0] = GAW'(r_mx6) << (F + 1);
    assign w_gnum[1] = GAW'(r_my6) << (F + 1);

    sdcd_div #(
        .DW    (RB),
        .QB    (GB),
        .LANES (2),
        .SDW   (SGW)
    ) u_div_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_num   (w_gnum),
        .i_den   (r_n6),
        .i_side  ({r_diff6, r_nx6, r_ny6, r_zero6}),
        .o_valid (w_gd_v),
        .o_quo   (w_gd_q),
        .o_den   (w_gd_n),
        .o_side  (w_gd_side)
    );

    // stage 7: round the gradient magnitudes
    logic            r_v7;
    logic [GB-1:0]   r_gx7, r_gy7;
    logic [RB-1:0]   r_n7;
    logic [SGW-1:0]  r_side7;
    logic [GB:0]     w_gx_sum, w_gy_sum;

    assign w_gx_sum = {1'b0, w_gd_q[0]} + 1'b1;
    assign w_gy_sum = {1'b0, w_gd_q[1]} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_gd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx7   <= w_gx_sum[GB:1];
            r_gy7   <= w_gy_sum[GB:1];
            r_n7    <= w_gd_n;
            r_side7 <= w_gd_side;
        end
    end

    // stage 8: curvature products
    logic             r_v8;
    logic [2*GB-1:0]  r_pxx, r_pyy, r_pxy;
    logic [RB-1:0]    r_n8;
    logic [SHW-1:0]   r_side8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pxx   <= r_gy7 * r_gy7;
            r_pyy   <= r_gx7 * r_gx7;
            r_pxy   <= r_gx7 * r_gy7;
            r_n8    <= r_n7;
            r_side8 <= {r_side7, r_gx7, r_gy7};
        end
    end

    // Hessian divisions: 2*product / n
    logic [2:0][HAW-1:0]  w_hnum;
    logic                 w_hd_v;
    logic [2:0][QH-1:0]   w_hd_q;
    logic [RB-1:0]        w_hd_n;
    logic [SHW-1:0]       w_hd_side;

    assign w_hnum[0] = HAW'({r_pxx, 1'b0});
    assign w_hnum[1] = HAW'({r_pyy, 1'b0});
    assign w_hnum[2] = HAW'({r_pxy, 1'b0});

    sdcd_div #(
        .DW    (RB),
        .QB    (QH),
        .LANES (3),
        .SDW   (SHW)
    ) u_div_hess (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_num   (w_hnum),
        .i_den   (r_n8),
        .i_side  (r_side8),
        .o_valid (w_hd_v),
        .o_quo   (w_hd_q),
        .o_den   (w_hd_n),
        .o_side  (w_hd_side)
    );

    // stage 9: rounding, signs, saturation
    logic [OW-1:0]          r_fin;
    logic [OW-1:0]          w_fin;
    logic signed [DFW-1:0]  w_diff;
    logic                   w_nx, w_ny, w_zero, w_sneg;
    logic [GB-1:0]          w_gx, w_gy;
    logic [DFW-1:0]         w_dmag;
    logic [QH:0]            w_hxx_sum, w_hyy_sum, w_hxy_sum;
    logic [W-1:0]           w_cost, w_grx, w_gry, w_hxx, w_hyy, w_hxy;

    assign w_diff = w_hd_side[SHW-1:SHW-DFW];
    assign w_nx   = w_hd_side[2*GB+2];
    assign w_ny   = w_hd_side[2*GB+1];
    assign w_zero = w_hd_side[2*GB];
    assign w_gx   = w_hd_side[2*GB-1:GB];
    assign w_gy   = w_hd_side[GB-1:0];
    assign w_sneg = !r_closer;

    assign w_dmag    = w_diff[DFW-1] ? DFW'(-w_diff) : w_diff;
    assign w_hxx_sum = {1'b0, w_hd_q[0]} + 1'b1;
    assign w_hyy_sum = {1'b0, w_hd_q[1]} + 1'b1;
    assign w_hxy_sum = {1'b0, w_hd_q[2]} + 1'b1;

    always_comb begin
        w_cost = f_sat(w_diff[DFW-1] ^ w_sneg, MB'(w_dmag));
        w_grx  = f_sat(!w_nx ^ w_sneg, MB'(w_gx));
        w_gry  = f_sat(!w_ny ^ w_sneg, MB'(w_gy));
        w_hxx  = f_sat(!w_sneg, MB'(w_hxx_sum[QH:1]));
        w_hyy  = f_sat(!w_sneg, MB'(w_hyy_sum[QH:1]));
        w_hxy  = f_sat(w_nx ^ w_ny ^ w_sneg, MB'(w_hxy_sum[QH:1]));
        // coincident points: derivatives forced to zero
        if (w_zero) begin
            w_grx = '0;
            w_gry = '0;
            w_hxx = '0;
            w_hyy = '0;
            w_hxy = '0;
        end
        w_fin = {w_zero, w_hxy, w_hyy, w_hxx, w_gry, w_grx, w_cost};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else if (w_en) begin
            r_v9 <= w_hd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= w_fin;
        end
    end

    // two-entry output queue
    logic [OW-1:0] r_q0, r_q1;
    logic          w_to_head;

    assign w_push    = r_v9 && w_en;
    assign w_pop     = (r_cnt != 2'd0) && m_axis_tready;
    assign w_to_head = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_to_head) begin
            r_q0 <= r_fin;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
        if (w_push && !w_to_head) begin
            r_q1 <= r_fin;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = ODW'(r_q0[6*W-1:0]);
    assign m_axis_tuser  = r_q0[6*W];

    // coincident points carry no derivative terms
    a_zero_derivs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (r_q0[6*W-1:W] == '0))
        else $error("derivatives not zero on coincident points");

    // the queue never takes a result without room for it
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_cnt == 2'd2) |-> m_axis_tready)
        else $error("output queue overflow");

    // with positive sign the diagonal Hessian terms are never positive
    a_diag_sign : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_closer) |->
            ((r_q0[4*W-1] || r_q0[4*W-1:3*W] == '0) &&
             (r_q0[5*W-1] || r_q0[5*W-1:4*W] == '0)))
        else $error("diagonal Hessian term has wrong sign");

endmodule

FILE: sv/sdcd_sqrt.sv
// sdcd_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// no package dependencies; carries side data along with each request
module sdcd_sqrt #(
    parameter int RB  = 33,
    parameter int SDW = 66
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RB-1:0]   i_rad,
    input  logic [SDW-1:0]    i_side,
    output logic              o_valid,
    output logic [RB-1:0]     o_root,
    output logic [RB+1:0]     o_rem,
    output logic [SDW-1:0]    o_side
);

    localparam int SW = 2 * RB;
    localparam int RW = RB + 2;

    logic            r_v    [1:RB];
    logic [SW-1:0]   r_sh   [1:RB];
    logic [RB-1:0]   r_root [1:RB];
    logic [RW-1:0]   r_rem  [1:RB];
    logic [SDW-1:0]  r_side [1:RB];

    genvar k;
    generate
        for (k = 1; k <= RB; k++) begin : g_st
            logic            p_v;
            logic [SW-1:0]   p_sh;
            logic [RB-1:0]   p_root;
            logic [RW-1:0]   p_rem;
            logic [SDW-1:0]  p_side;
            logic [RW:0]     w_t;
            logic [RW:0]     w_trial;
            logic            w_ge;

            // previous stage or the input port
            if (k == 1) begin : g_first
                assign p_v    = i_valid;
                assign p_sh   = i_rad;
                assign p_root = '0;
                assign p_rem  = '0;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v    = r_v[k-1];
                assign p_sh   = r_sh[k-1];
                assign p_root = r_root[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_side = r_side[k-1];
            end

            // bring down two radicand bits, try root*4+1
            assign w_t     = {p_rem[RB:0], p_sh[SW-1:SW-2]};
            assign w_trial = {1'b0, p_root, 2'b01};
            assign w_ge    = (w_t >= w_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sh[k]   <= {p_sh[SW-3:0], 2'b00};
                    r_root[k] <= {p_root[RB-2:0], w_ge};
                    r_rem[k]  <= w_ge ? RW'(w_t - w_trial) : w_t[RW-1:0];
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[RB];
    assign o_root  = r_root[RB];
    assign o_rem   = r_rem[RB];
    assign o_side  = r_side[RB];

endmodule

FILE: sv/sdcd_div.sv
// sdcd_div: pipelined restoring divider, one quotient bit per stage, several lanes
// share one divisor; no package dependencies
module sdcd_div #(
    parameter int DW    = 33,
    parameter int QB    = 18,
    parameter int LANES = 2,
    parameter int SDW   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [LANES-1:0][DW+QB-1:0]    i_num,
    input  logic [DW-1:0]                  i_den,
    input  logic [SDW-1:0]                 i_side,
    output logic                           o_valid,
    output logic [LANES-1:0][QB-1:0]       o_quo,
    output logic [DW-1:0]                  o_den,
    output logic [SDW-1:0]                 o_side
);

    localparam int AW = DW + QB;

    logic                         r_v    [1:QB];
    logic [LANES-1:0][AW-1:0]     r_acc  [1:QB];
    logic [DW-1:0]                r_den  [1:QB];
    logic [SDW-1:0]               r_side [1:QB];

    genvar k;
    generate
        for (k = 1; k <= QB; k++) begin : g_st
            logic                       p_v;
            logic [LANES-1:0][AW-1:0]   p_acc;
            logic [DW-1:0]              p_den;
            logic [SDW-1:0]             p_side;
            logic [LANES-1:0][AW-1:0]   w_acc;

            if (k == 1) begin : g_first
                assign p_v    = i_valid;
                assign p_acc  = i_num;
                assign p_den  = i_den;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v    = r_v[k-1];
                assign p_acc  = r_acc[k-1];
                assign p_den  = r_den[k-1];
                assign p_side = r_side[k-1];
            end

            // shift in one dividend bit per lane, subtract when it fits
            always_comb begin
                logic [DW:0]   t;
                logic          ge;
                logic [DW:0]   up;
                for (int l = 0; l < LANES; l++) begin
                    t  = p_acc[l][AW-1:QB-1];
                    ge = (t >= {1'b0, p_den});
                    up = ge ? (t - {1'b0, p_den}) : t;
                    w_acc[l] = {up[DW-1:0], p_acc[l][QB-2:0], ge};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc[k]  <= w_acc;
                    r_den[k]  <= p_den;
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    // quotient ends up in the low bits of each accumulator
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_acc[QB][l][QB-1:0];
        end
    end

    assign o_valid = r_v[QB];
    assign o_den   = r_den[QB];
    assign o_side  = r_side[QB];

endmodule
